// ===== rtl/core/stepper_step_dir_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// stepper step/dir controller assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef STEPPER_STEP_DIR_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_STEP_DIR_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

// next-cycle implication, sampled on clk, off during reset
`define STP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

// ===== rtl/core/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// shared types, codes and widths of the step/dir controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stp_pkg;

	localparam int TARGET_W    = 24;
	localparam int SPAN_W      = 23;
	localparam int MARGIN_W    = 8;
	localparam int DEBOUNCE_W  = 16;
	localparam int GAUGE_W     = 10;
	localparam int REMAIN_W    = 24;
	localparam int OUT_POS_W   = 24;
	localparam int OPCODE_W    = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 23;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	// result field positions in m_tdata
	localparam int OUT_HOMED_BIT = 28;
	localparam int OUT_ERROR_BIT = 29;

	localparam logic [SPAN_W-1:0]     SPAN_RESET       = '0;
	localparam logic [MARGIN_W-1:0]   MARGIN_RESET     = 8'd5;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic                  STALL_STOP_RESET = 1'b1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK = 3'd0,
		OP_MOVE = 3'd1,
		OP_JOG  = 3'd2,
		OP_STOP = 3'd3,
		OP_HOME = 3'd4
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SPAN       = 2'd0,
		CFG_MARGIN     = 2'd1,
		CFG_DEBOUNCE   = 2'd2,
		CFG_STALL_STOP = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SPAN_W-1:0]     travel_span;
		logic [MARGIN_W-1:0]   safety_margin;
		logic [DEBOUNCE_W-1:0] stall_debounce_ticks;
		logic                  stall_stop_enable;
	} cfg_t;

	// target already clamped to the travel window
	typedef struct packed {
		op_t                  opcode;
		logic [TARGET_W-1:0]  target_position;
		logic                 jog_forward;
		logic                 stall_ind;
		logic [GAUGE_W-1:0]   stall_gauge;
	} item_t;

	typedef struct packed {
		logic                 error_code;
		logic                 homed_flag;
		logic                 stall_seen;
		logic                 moving;
		logic [OUT_POS_W-1:0] position_now;
		logic                 dir_level;
		logic                 step_level;
	} result_t;

endpackage

// ===== rtl/core/stp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// stp_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [stp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output stp_pkg::cfg_t                    cfg
);
	import stp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.travel_span          <= SPAN_RESET;
			cfg_q.safety_margin        <= MARGIN_RESET;
			cfg_q.stall_debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.stall_stop_enable    <= STALL_STOP_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SPAN:       cfg_q.travel_span          <= cfg_wdata[SPAN_W-1:0];
				CFG_MARGIN:     cfg_q.safety_margin        <= cfg_wdata[MARGIN_W-1:0];
				CFG_DEBOUNCE:   cfg_q.stall_debounce_ticks <= cfg_wdata[DEBOUNCE_W-1:0];
				CFG_STALL_STOP: cfg_q.stall_stop_enable    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/stp_in_stage.sv =====
// ----------------------------------------------------------------------------
// stp_in_stage
// input register; unpacks the stream word and clamps the move target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_in_stage (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [stp_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [stp_pkg::OPCODE_W-1:0]     s_tuser,
	input  logic                             advance,
	input  stp_pkg::cfg_t                    cfg,
	output logic                             valid_s1,
	output stp_pkg::item_t                   item_s1
);
	import stp_pkg::*;

	logic signed [TARGET_W-1:0] lo_bound;
	logic signed [TARGET_W-1:0] hi_raw;
	logic signed [TARGET_W-1:0] hi_bound;
	logic signed [TARGET_W-1:0] target_in;
	logic signed [TARGET_W-1:0] target_clamped;
	item_t                      item_in;

	// window [margin, span - margin], upper edge raised to the lower one
	assign lo_bound  = signed'(TARGET_W'(cfg.safety_margin));
	assign hi_raw    = signed'(TARGET_W'(cfg.travel_span)) - lo_bound;
	assign hi_bound  = (hi_raw < lo_bound) ? lo_bound : hi_raw;
	assign target_in = signed'(s_tdata[TARGET_W-1:0]);

	always_comb begin
		if (target_in < lo_bound) begin
			target_clamped = lo_bound;
		end else if (target_in > hi_bound) begin
			target_clamped = hi_bound;
		end else begin
			target_clamped = target_in;
		end
	end

	always_comb begin
		item_in.opcode          = op_t'(s_tuser);
		item_in.target_position = target_clamped;
		item_in.jog_forward     = s_tdata[TARGET_W];
		item_in.stall_ind       = s_tdata[TARGET_W+1];
		item_in.stall_gauge     = s_tdata[TARGET_W+2 +: GAUGE_W];
	end

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== rtl/core/stp_core.sv =====
// ----------------------------------------------------------------------------
// stp_core
// motion state and the per-item update: ticks, moves, jogs, stop, home
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_core #(
	parameter int POSITION_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  stp_pkg::item_t    item,
	input  stp_pkg::cfg_t     cfg,
	output stp_pkg::result_t  res
);
	import stp_pkg::*;

	localparam int WIDE_W = (POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W;
	localparam int DIST_W = WIDE_W + 1;

	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [REMAIN_W-1:0]      remain_q, remain_n;
	logic                     jog_q, jog_n;
	logic                     phase_q, phase_n;
	logic                     fwd_q, fwd_n;
	logic                     run_q, run_n;
	logic                     homed_q, homed_n;
	logic [DEBOUNCE_W-1:0]    stall_cnt_q, stall_cnt_n;

	logic                     stall_pulse;
	logic                     move_err;
	logic                     stall_sample;
	logic [DEBOUNCE_W-1:0]    stall_need;
	logic [DEBOUNCE_W-1:0]    stall_cnt_inc;
	logic                     stall_stop;
	logic signed [DIST_W-1:0] move_delta;
	logic [DIST_W-1:0]        dist_mag;
	logic [REMAIN_W-1:0]      remain_move;
	logic [POSITION_BITS-1:0] pos_step;
	logic [WIDE_W-1:0]        pos_wide;

	assign stall_sample  = item.stall_ind || (item.stall_gauge == '0);
	assign stall_need    = (cfg.stall_debounce_ticks == '0) ? DEBOUNCE_W'(1)
	                                                         : cfg.stall_debounce_ticks;
	assign stall_cnt_inc = (&stall_cnt_q) ? stall_cnt_q : stall_cnt_q + 1'b1;
	assign pos_step      = fwd_q ? pos_q + 1'b1 : pos_q - 1'b1;

	// signed distance from the current position to the clamped target
	assign move_delta  = DIST_W'(signed'(item.target_position)) - DIST_W'(signed'(pos_q));
	assign dist_mag    = move_delta[DIST_W-1] ? DIST_W'(-move_delta) : DIST_W'(move_delta);
	assign remain_move = (|dist_mag[DIST_W-1:REMAIN_W]) ? {REMAIN_W{1'b1}}
	                                                    : dist_mag[REMAIN_W-1:0];

	always_comb begin
		pos_n       = pos_q;
		remain_n    = remain_q;
		jog_n       = jog_q;
		phase_n     = phase_q;
		fwd_n       = fwd_q;
		run_n       = run_q;
		homed_n     = homed_q;
		stall_cnt_n = stall_cnt_q;
		stall_pulse = 1'b0;
		move_err    = 1'b0;
		stall_stop  = 1'b0;
		case (item.opcode)
			OP_TICK: begin
				if (stall_sample) begin
					stall_pulse = (stall_cnt_inc >= stall_need);
					stall_cnt_n = stall_pulse ? '0 : stall_cnt_inc;
				end else begin
					stall_cnt_n = '0;
				end
				stall_stop = stall_pulse && jog_q && run_q && cfg.stall_stop_enable;
				if (stall_stop) begin
					remain_n = '0;
					run_n    = 1'b0;
					jog_n    = 1'b0;
					phase_n  = 1'b0;
				end else if (run_q) begin
					if (jog_q || (remain_q != '0)) begin
						phase_n = !phase_q;
						// rising edge on the step pin
						if (!phase_q) begin
							if (!jog_q) begin
								remain_n = remain_q - 1'b1;
							end
							pos_n = pos_step;
						end
					end else begin
						run_n = 1'b0;
					end
				end
			end
			OP_MOVE: begin
				if (!homed_q) begin
					move_err = 1'b1;
				end else if (move_delta != '0) begin
					fwd_n    = !move_delta[DIST_W-1];
					remain_n = remain_move;
					run_n    = 1'b1;
					jog_n    = 1'b0;
				end
			end
			OP_JOG: begin
				fwd_n    = item.jog_forward;
				remain_n = '0;
				jog_n    = 1'b1;
				run_n    = 1'b1;
			end
			OP_STOP: begin
				remain_n = '0;
				run_n    = 1'b0;
				jog_n    = 1'b0;
				phase_n  = 1'b0;
			end
			OP_HOME: begin
				pos_n   = '0;
				homed_n = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			remain_q    <= '0;
			jog_q       <= 1'b0;
			phase_q     <= 1'b0;
			fwd_q       <= 1'b1;
			run_q       <= 1'b0;
			homed_q     <= 1'b0;
			stall_cnt_q <= '0;
		end else if (fire) begin
			pos_q       <= pos_n;
			remain_q    <= remain_n;
			jog_q       <= jog_n;
			phase_q     <= phase_n;
			fwd_q       <= fwd_n;
			run_q       <= run_n;
			homed_q     <= homed_n;
			stall_cnt_q <= stall_cnt_n;
		end
	end

	assign pos_wide = WIDE_W'(pos_n);

	always_comb begin
		res.step_level   = phase_n;
		res.dir_level    = fwd_n;
		res.position_now = pos_wide[OUT_POS_W-1:0];
		res.moving       = run_n;
		res.stall_seen   = stall_pulse;
		res.homed_flag   = homed_n;
		res.error_code   = move_err;
	end

endmodule

// ===== rtl/core/stepper_step_dir_controller_top.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_controller_top
// step/direction pulse generator with position counter and stall debounce
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is one command or one tick and gives
// exactly one result transfer on the master stream. The block takes one item
// every clock unless the master side holds it back: an item sits in the input
// register (where the move target is clamped to the travel window), then the
// motion state updates and the result lands in the output register, where it
// is presented until it transfers when the master side is ready.
// The rate is set by the state update loop in the core. Back pressure on the
// master side stalls the input register and, through it, s_tready.
// Configuration writes go straight to the register file and are meant to be
// done while no item is in flight.
`timescale 1ns / 1ps

module stepper_step_dir_controller_top #(
	parameter int POSITION_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave stream: commands and ticks
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [23:0] target_position, [24] jog_forward, [25] stall_ind,
	// [35:26] stall_gauge, [39:36] zero
	input  logic [stp_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [2:0] opcode
	input  logic [stp_pkg::OPCODE_W-1:0]     s_tuser,
	// master stream: one result per item
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] step_level, [1] dir_level, [25:2] position_now, [26] moving,
	// [27] stall_seen, [28] homed_flag, [29] error_code, [31:30] zero
	output logic [stp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [stp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import stp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;      // output register can take a new result
	logic    fire;         // item in the input register executes this cycle
	result_t res;
	result_t res_q;
	logic    m_valid_q;

	stp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	stp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	stp_core #(
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// output register frees when empty or when its result transfers
	assign advance = !m_valid_q || m_tready;
	assign fire    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00,
	                   res_q.error_code,
	                   res_q.homed_flag,
	                   res_q.stall_seen,
	                   res_q.moving,
	                   res_q.position_now,
	                   res_q.dir_level,
	                   res_q.step_level};

endmodule

// ===== rtl/core/stp_port_chk.sv =====
// ----------------------------------------------------------------------------
// stp_port_chk
// port-level checks of the step/dir controller, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_step_dir_controller_top_defines.svh"

module stp_port_chk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [stp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import stp_pkg::*;

	logic seen_homed_q;

	// remembers that a result has already shown the axis homed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_homed_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[OUT_HOMED_BIT]) begin
			seen_homed_q <= 1'b1;
		end
	end

	// a stalled result holds
	`STP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// an empty output side never blocks the input
	`STP_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

	// with an item held at the input, input ready follows output room
	`STP_ASSERT_NEXT(a_ready_follows, s_tvalid && s_tready, s_tready == (!m_tvalid || m_tready))

	// homing is never lost once shown
	`STP_ASSERT_NOW(a_homed_sticky, m_tvalid && seen_homed_q, m_tdata[OUT_HOMED_BIT])

	// a refused move only happens before homing
	`STP_ASSERT_NOW(a_err_not_homed, m_tvalid && m_tdata[OUT_ERROR_BIT], !m_tdata[OUT_HOMED_BIT])

endmodule

bind stepper_step_dir_controller_top stp_port_chk u_port_chk (.*);

// ===== sim/tb_stepper_step_dir_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_step_dir_controller_top
// self-checking bench for the step/dir pulse generator
// ----------------------------------------------------------------------------
// Commands and ticks go in on the slave stream, and one status word per
// transfer comes back on the master stream. A motion tracker inside the bench
// mirrors the position counter, the move/jog state and the stall debounce. It
// predicts every status word and compares it field by field in arrival order.
// A short directed run covers homing, a refused move, clamping at both ends,
// jog, stop and the unused opcodes. Random phases follow, each under its own
// register setting. Both stream sides idle at random, with quiet stretches.
`timescale 1ns / 1ps

module tb_stepper_step_dir_controller_top;
	import stp_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_SPARE_LO     = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_MID    = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI     = 3'd7;
	localparam int                  ITEMS_PER_PHASE = 100;
	localparam int                  NUM_PHASES      = 6;
	localparam int                  RUN_LIMIT_NS    = 2_000_000;
	localparam int                  MAX_REPORTS     = 10;

	// tracks the motion state and holds the status words still to arrive
	class motion_scoreboard;
		logic [SPAN_W-1:0]     span;
		logic [MARGIN_W-1:0]   margin;
		logic [DEBOUNCE_W-1:0] debounce;
		logic                  stop_en;
		logic [OUT_POS_W-1:0]  pos;
		logic [REMAIN_W-1:0]   remain;
		logic                  jogging;
		logic                  phase;
		logic                  fwd;
		logic                  running;
		logic                  homed;
		logic [DEBOUNCE_W-1:0] stall_cnt;
		result_t               expected_q[$];
		int                    mismatches;

		function new();
			span       = SPAN_RESET;
			margin     = MARGIN_RESET;
			debounce   = DEBOUNCE_RESET;
			stop_en    = STALL_STOP_RESET;
			pos        = '0;
			remain     = '0;
			jogging    = 1'b0;
			phase      = 1'b0;
			fwd        = 1'b1;
			running    = 1'b0;
			homed      = 1'b0;
			stall_cnt  = '0;
			mismatches = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SPAN:       span     = val[SPAN_W-1:0];
				CFG_MARGIN:     margin   = val[MARGIN_W-1:0];
				CFG_DEBOUNCE:   debounce = val[DEBOUNCE_W-1:0];
				CFG_STALL_STOP: stop_en  = val[0];
				default: ;
			endcase
		endfunction

		function void halt();
			remain  = '0;
			running = 1'b0;
			jogging = 1'b0;
			phase   = 1'b0;
		endfunction

		// advance the motion state by one accepted command and queue its status
		function void note_command(item_t it);
			result_t               want;
			logic [DEBOUNCE_W-1:0] need;
			logic                  stall_hit;
			logic                  refused;
			logic                  halted;
			longint                lo;
			longint                hi;
			longint                aim;
			longint                offset;
			longint                mag;
			stall_hit = 1'b0;
			refused   = 1'b0;
			halted    = 1'b0;
			case (it.opcode)
				OP_TICK: begin
					need = (debounce == '0) ? 16'd1 : debounce;
					if (it.stall_ind || it.stall_gauge == '0) begin
						if (stall_cnt != '1)
							stall_cnt++;
						if (stall_cnt >= need) begin
							stall_hit = 1'b1;
							stall_cnt = '0;
						end
					end else begin
						stall_cnt = '0;
					end
					// a debounced stall ends a jog without a step on this tick
					if (stall_hit && jogging && running && stop_en) begin
						halt();
						halted = 1'b1;
					end
					if (!halted && running) begin
						if (jogging || remain != '0) begin
							phase = !phase;
							if (phase) begin
								if (!jogging && remain != '0)
									remain--;
								pos = fwd ? pos + 1'b1 : pos - 1'b1;
							end
						end else begin
							running = 1'b0;
						end
					end
				end
				OP_MOVE: begin
					if (!homed) begin
						refused = 1'b1;
					end else begin
						lo = longint'(margin);
						hi = longint'(span) - longint'(margin);
						if (hi < lo)
							hi = lo;
						aim = longint'($signed(it.target_position));
						if (aim < lo)
							aim = lo;
						if (aim > hi)
							aim = hi;
						offset = aim - longint'($signed(pos));
						if (offset != 0) begin
							mag     = (offset > 0) ? offset : -offset;
							fwd     = offset > 0;
							remain  = (mag > longint'(24'hFFFFFF)) ? '1 : mag[REMAIN_W-1:0];
							running = 1'b1;
							jogging = 1'b0;
						end
					end
				end
				OP_JOG: begin
					fwd     = it.jog_forward;
					remain  = '0;
					jogging = 1'b1;
					running = 1'b1;
				end
				OP_STOP: halt();
				OP_HOME: begin
					pos   = '0;
					homed = 1'b1;
				end
				default: ;
			endcase
			want.step_level   = phase;
			want.dir_level    = fwd;
			want.position_now = pos;
			want.moving       = running;
			want.stall_seen   = stall_hit;
			want.homed_flag   = homed;
			want.error_code   = refused;
			expected_q.push_back(want);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] word);
			result_t got;
			result_t want;
			got = result_t'(word[$bits(result_t)-1:0]);
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: status transfer %h with nothing expected", $time, word);
				return;
			end
			want = expected_q.pop_front();
			if (got.step_level !== want.step_level || got.dir_level !== want.dir_level ||
				got.position_now !== want.position_now || got.moving !== want.moving ||
				got.stall_seen !== want.stall_seen || got.homed_flag !== want.homed_flag ||
				got.error_code !== want.error_code ||
				word[OUT_TDATA_W-1:$bits(result_t)] !== '0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: mismatch exp step=%b dir=%b pos=%0d mov=%b stall=%b home=%b err=%b",
						$time, want.step_level, want.dir_level, $signed(want.position_now),
						want.moving, want.stall_seen, want.homed_flag, want.error_code);
					$display("%0t:          got step=%b dir=%b pos=%0d mov=%b stall=%b home=%b err=%b pad=%b",
						$time, got.step_level, got.dir_level, $signed(got.position_now),
						got.moving, got.stall_seen, got.homed_flag, got.error_code,
						word[OUT_TDATA_W-1:$bits(result_t)]);
				end
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic [OPCODE_W-1:0]     s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    cfg_we;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;

	motion_scoreboard sb = new();

	// idling on both sides is switched off for some stretches
	bit idle_on = 1'b1;
	// ticks left in the current burst of stall samples
	int stall_run = 0;

	// register settings per random phase, extremes included
	logic [SPAN_W-1:0]     span_set[NUM_PHASES]     = '{23'd1000, 23'h7FFFFF, 23'd0,
		23'd200, 23'd500, 23'd60};
	logic [MARGIN_W-1:0]   margin_set[NUM_PHASES]   = '{8'd5, 8'd0, 8'd0, 8'd255, 8'd255, 8'd10};
	logic [DEBOUNCE_W-1:0] debounce_set[NUM_PHASES] = '{16'd3, 16'd1, 16'd0, 16'hFFFF,
		16'd4, 16'd2};
	logic                  stop_set[NUM_PHASES]     = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

	stepper_step_dir_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic item_t cmd(op_t op, logic [TARGET_W-1:0] tgt, logic jf, logic flag,
		logic [GAUGE_W-1:0] gauge);
		item_t it;
		it.opcode          = op;
		it.target_position = tgt;
		it.jog_forward     = jf;
		it.stall_ind       = flag;
		it.stall_gauge     = gauge;
		return it;
	endfunction

	// random command: mostly ticks, moves near the current position or the window
	// ends, some jogs, stall bursts that can trip a short debounce, and a little noise
	task automatic make_item(output item_t it);
		int                  pick;
		int                  sel;
		int                  delta;
		int                  cap;
		logic [TARGET_W-1:0] edge_pos;
		it.opcode          = OP_TICK;
		it.target_position = TARGET_W'($urandom());
		it.jog_forward     = 1'($urandom_range(0, 1));
		it.stall_ind       = 1'($urandom_range(0, 1));
		it.stall_gauge     = GAUGE_W'($urandom_range(0, 1023));
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			if (stall_run > 0) begin
				stall_run--;
				if ($urandom_range(0, 1)) begin
					it.stall_ind = 1'b1;
				end else begin
					it.stall_ind   = 1'b0;
					it.stall_gauge = '0;
				end
			end else begin
				it.stall_ind = ($urandom_range(0, 19) == 0);
				if (!it.stall_ind)
					it.stall_gauge = GAUGE_W'($urandom_range(1, 1023));
				if ($urandom_range(0, 24) == 0) begin
					cap = (sb.debounce < 16'd10) ? int'(sb.debounce) + 2 : 12;
					stall_run = $urandom_range(1, cap);
				end
			end
		end else if (pick < 75) begin
			it.opcode = OP_MOVE;
			sel   = $urandom_range(0, 9);
			delta = int'($urandom_range(0, 40)) - 20;
			if (sel < 6) begin
				it.target_position = sb.pos + delta[TARGET_W-1:0];
			end else if (sel < 8) begin
				// around the ends of the travel window
				edge_pos = (sel == 6) ? TARGET_W'(sb.margin) :
					TARGET_W'(sb.span) - TARGET_W'(sb.margin);
				delta = int'($urandom_range(0, 4)) - 2;
				it.target_position = edge_pos + delta[TARGET_W-1:0];
			end
		end else if (pick < 83) begin
			it.opcode = OP_JOG;
		end else if (pick < 89) begin
			it.opcode = OP_STOP;
		end else if (pick < 93) begin
			it.opcode = OP_HOME;
		end else begin
			it.opcode = op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
	endtask

	// one slave transfer; valid stays up when no gap is drawn
	task automatic send_command(input item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({it.stall_gauge, it.stall_ind, it.jog_forward,
			it.target_position});
		s_tuser  <= it.opcode;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(it);
	endtask

	// caller lowers cfg_we after the last write of a batch
	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	// wait for every status word, then let the pipeline empty
	task automatic settle();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// master side: random hold-offs on tready
	initial begin
		int hold;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = idle_on ? $urandom_range(0, 3) : 0;
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		item_t it;
		int    ph;
		int    k;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_TICK;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_SPAN;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed run under the reset register values
		send_command(cmd(OP_TICK, 24'h000000, 1'b0, 1'b0, 10'd0));     // idle tick, gauge stall
		send_command(cmd(OP_MOVE, 24'd100, 1'b1, 1'b0, 10'h3FF));      // refused, not homed
		send_command(cmd(op_t'(OP_SPARE_LO), 24'hFFFFFF, 1'b1, 1'b1, 10'h3FF));
		send_command(cmd(op_t'(OP_SPARE_HI), 24'h555555, 1'b0, 1'b1, 10'h155));
		send_command(cmd(OP_JOG, 24'h000000, 1'b0, 1'b0, 10'h3FF));    // jog backward
		repeat (3) send_command(cmd(OP_TICK, 24'h000000, 1'b0, 1'b0, 10'h3FF));
		send_command(cmd(OP_STOP, 24'h000000, 1'b0, 1'b0, 10'h3FF));
		send_command(cmd(OP_HOME, 24'h000000, 1'b0, 1'b0, 10'h3FF));
		send_command(cmd(OP_MOVE, 24'h800000, 1'b0, 1'b0, 10'h3FF));   // clamps to the low end
		repeat (2) send_command(cmd(OP_TICK, 24'h000000, 1'b0, 1'b0, 10'h3FF));
		send_command(cmd(OP_MOVE, 24'h7FFFFF, 1'b0, 1'b0, 10'h3FF));   // clamps to the high end
		send_command(cmd(OP_JOG, 24'h000000, 1'b1, 1'b0, 10'h3FF));    // jog replaces the move
		send_command(cmd(OP_TICK, 24'h000000, 1'b0, 1'b1, 10'h3FF));   // flag stall
		send_command(cmd(OP_TICK, 24'h000000, 1'b0, 1'b0, 10'd0));     // gauge stall
		send_command(cmd(OP_MOVE, 24'd3, 1'b0, 1'b0, 10'h3FF));
		send_command(cmd(op_t'(OP_SPARE_MID), 24'h0F0F0F, 1'b1, 1'b0, 10'h2AA));
		send_command(cmd(OP_STOP, 24'h000000, 1'b0, 1'b0, 10'h3FF));
		send_command(cmd(OP_TICK, 24'h000000, 1'b0, 1'b0, 10'h3FF));
		s_tvalid <= 1'b0;
		settle();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_register(CFG_SPAN, CFG_DATA_W'(span_set[ph]));
			write_register(CFG_MARGIN, CFG_DATA_W'(margin_set[ph]));
			write_register(CFG_DEBOUNCE, CFG_DATA_W'(debounce_set[ph]));
			write_register(CFG_STALL_STOP, CFG_DATA_W'(stop_set[ph]));
			cfg_we <= 1'b0;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 40 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				make_item(it);
				send_command(it);
			end
			s_tvalid <= 1'b0;
			settle();
		end

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#(RUN_LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/stp_pkg.sv
rtl/core/stp_cfg_regs.sv
rtl/core/stp_in_stage.sv
rtl/core/stp_core.sv
rtl/core/stepper_step_dir_controller_top.sv
rtl/core/stp_port_chk.sv
sim/tb_stepper_step_dir_controller_top.sv
